// ===== design/nearest_waypoint_speed_lookup_macros.svh =====
// Assertion macros for the nearest waypoint speed lookup.
// Used by the top level; no other dependencies.
`ifndef NEAREST_WAYPOINT_SPEED_LOOKUP_MACROS_SVH
`define NEAREST_WAYPOINT_SPEED_LOOKUP_MACROS_SVH
`ifndef ASSERT_OFF
`define NWSL_ASSERT_IMP(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("nwsl assertion failed");
`define NWSL_ASSERT_NXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("nwsl assertion failed");
`else
`define NWSL_ASSERT_IMP(label, clock, resetn, ante, cons)
`define NWSL_ASSERT_NXT(label, clock, resetn, ante, cons)
`endif
`endif

// ===== design/nwsl_pkg.sv =====
// Shared types, constants and codes for the nearest waypoint speed lookup.
// No dependencies; imported by every module of the block.
package nwsl_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int POS_W      = 24;
    localparam int SPD_W      = 16;
    localparam int CFG_SPD_W  = 15;
    localparam int OUT_IDX_W  = 10;
    localparam int ABS_W      = POS_W;
    localparam int SQ_W       = 2 * ABS_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CFG_SPD_W;

    localparam logic [DIST_W-1:0]    DIST_BOUND    = DIST_W'(64'd999999000000);
    localparam logic [CFG_SPD_W-1:0] MAX_SPEED_RST = CFG_SPD_W'(900);
    localparam logic [CFG_SPD_W-1:0] MIN_SPEED_RST = CFG_SPD_W'(600);

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_MODE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKUP_EN = CFG_IDX_W'(2);

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [SPD_W-1:0] point_speed_in;
        logic                    last_point;
        logic                    clear_flag;
    } item_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]    closest_index;
        logic signed [SPD_W-1:0] speed_out;
    } result_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [SPD_W-1:0] speed;
    } waypoint_t;

    typedef struct packed {
        logic load;
        logic set_mode;
        logic start;
        logic issue;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic query_ok;
        logic scan_last;
        logic pipe_busy;
        logic found;
        logic out_free;
    } stat_t;

endpackage

// ===== design/nearest_waypoint_speed_lookup.sv =====
// Nearest waypoint speed lookup, top level: controller plus datapath.
// Depends on nwsl_pkg, nwsl_ctrl, nwsl_datapath and the assertion macros.
//
// Usage: items arrive on the item channel (valid/ready). A load transaction
// stores one waypoint until a point marked last locks the path; a mode
// transaction sets or clears obstacle mode; a pose query scans the stored
// path and, if a point lies inside the distance bound, delivers one result
// transaction with the nearest index and the commanded speed.
// Loads and mode items do not hold the item channel. A query over N stored
// points keeps it busy while the controller works: one memory read per point
// through the single read port, a four-stage distance pipeline, settling of
// the last comparison and handover of the result; the next item is taken
// only once the controller is back in its idle state.
// The result sits in an output register; new items are taken while it waits.
// If the receiver stalls and a second query finishes, the controller holds
// in its final state until the result register frees.
// Reset clears the point count, path lock, obstacle mode and configuration
// registers to their defaults; waypoint memory contents are not cleared.
// Configuration writes via cfg_we/cfg_index/cfg_wdata take effect at once.
`include "nearest_waypoint_speed_lookup_macros.svh"

module nearest_waypoint_speed_lookup (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  nwsl_pkg::item_t                    item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output nwsl_pkg::result_t                  result,
    input  logic                               cfg_we,
    input  logic [nwsl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nwsl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import nwsl_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    nwsl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_cmd   (item.cmd),
        .stat       (stat),
        .ctrl       (ctrl)
    );

    nwsl_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .ctrl         (ctrl),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    `NWSL_ASSERT_IMP(a_no_accept_in_scan, clk, rst_n, ctrl.issue, !item_ready)
    `NWSL_ASSERT_NXT(a_scan_follows_start, clk, rst_n, ctrl.start, ctrl.issue)
    `NWSL_ASSERT_IMP(a_emit_after_drain, clk, rst_n, ctrl.emit, !stat.pipe_busy && stat.found)
    `NWSL_ASSERT_NXT(a_emit_sets_valid, clk, rst_n, ctrl.emit, result_valid)

endmodule

// ===== design/nwsl_datapath.sv =====
// Datapath: waypoint memory, path state, configuration registers,
// distance pipeline, best-match tracking and result register. Uses nwsl_pkg.
module nwsl_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  nwsl_pkg::item_t                    item,
    input  logic                               cfg_we,
    input  logic [nwsl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nwsl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  nwsl_pkg::ctrl_t                    ctrl,
    output nwsl_pkg::stat_t                    stat,
    output logic                               result_valid,
    input  logic                               result_ready,
    output nwsl_pkg::result_t                  result
);
    import nwsl_pkg::*;

    waypoint_t mem [MAX_POINTS];

    logic [CNT_W-1:0]     count_reg;
    logic                 locked_reg;
    logic                 obstacle_reg;
    logic [CFG_SPD_W-1:0] max_speed_reg;
    logic [CFG_SPD_W-1:0] min_speed_reg;
    logic                 lookup_en_reg;

    logic [IDX_W-1:0]        addr_reg;
    logic signed [POS_W-1:0] pose_x_reg;
    logic signed [POS_W-1:0] pose_y_reg;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    waypoint_t               rd_reg;
    logic [IDX_W-1:0]        idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic signed [SPD_W-1:0] spd2_reg, spd3_reg, spd4_reg;
    logic [ABS_W-1:0]        ax_reg, ay_reg;
    logic [SQ_W-1:0]         sx_reg, sy_reg;
    logic [DIST_W-1:0]       dist_reg;

    logic [DIST_W-1:0]       best_dist_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic signed [SPD_W-1:0] best_spd_reg;
    logic                    found_reg;

    logic                    result_valid_reg;
    result_t                 result_reg;

    logic                    store_pt;
    logic signed [POS_W:0]   dx, dy;
    logic [POS_W:0]          dx_abs, dy_abs;
    logic signed [SPD_W-1:0] speed_sel;

    assign store_pt = ctrl.load && !locked_reg && (count_reg < CNT_W'(MAX_POINTS));

    always_comb
    begin
        dx     = {rd_reg.x[POS_W-1], rd_reg.x} - {pose_x_reg[POS_W-1], pose_x_reg};
        dy     = {rd_reg.y[POS_W-1], rd_reg.y} - {pose_y_reg[POS_W-1], pose_y_reg};
        dx_abs = dx[POS_W] ? 25'(-dx) : 25'(dx);
        dy_abs = dy[POS_W] ? 25'(-dy) : 25'(dy);
    end

    always_comb
    begin
        speed_sel = best_spd_reg;
        if (best_spd_reg > $signed({1'b0, max_speed_reg}))
        begin
            speed_sel = $signed({1'b0, max_speed_reg});
        end
        if (obstacle_reg)
        begin
            speed_sel = $signed({1'b0, min_speed_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_pt)
        begin
            mem[count_reg[IDX_W-1:0]] <= '{x: item.pos_x, y: item.pos_y,
                                           speed: item.point_speed_in};
        end
        if (ctrl.issue)
        begin
            rd_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            locked_reg       <= 1'b0;
            obstacle_reg     <= 1'b0;
            max_speed_reg    <= MAX_SPEED_RST;
            min_speed_reg    <= MIN_SPEED_RST;
            lookup_en_reg    <= 1'b1;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (store_pt)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (ctrl.load && item.last_point)
            begin
                locked_reg <= 1'b1;
            end
            if (ctrl.set_mode)
            begin
                obstacle_reg <= !item.clear_flag;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_SPEED: max_speed_reg <= cfg_wdata[CFG_SPD_W-1:0];
                    CFG_MIN_SPEED: min_speed_reg <= cfg_wdata[CFG_SPD_W-1:0];
                    CFG_LOOKUP_EN: lookup_en_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (ctrl.start)
            begin
                found_reg <= 1'b0;
            end
            else if (v4_reg && (dist_reg < best_dist_reg))
            begin
                found_reg <= 1'b1;
            end
            if (ctrl.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            addr_reg      <= '0;
            pose_x_reg    <= item.pos_x;
            pose_y_reg    <= item.pos_y;
            best_dist_reg <= DIST_BOUND;
        end
        else
        begin
            if (ctrl.issue)
            begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
            if (v4_reg && (dist_reg < best_dist_reg))
            begin
                best_dist_reg <= dist_reg;
                best_idx_reg  <= idx4_reg;
                best_spd_reg  <= spd4_reg;
            end
        end
        idx1_reg <= addr_reg;
        idx2_reg <= idx1_reg;
        spd2_reg <= rd_reg.speed;
        ax_reg   <= dx_abs[ABS_W-1:0];
        ay_reg   <= dy_abs[ABS_W-1:0];
        idx3_reg <= idx2_reg;
        spd3_reg <= spd2_reg;
        sx_reg   <= ax_reg * ax_reg;
        sy_reg   <= ay_reg * ay_reg;
        idx4_reg <= idx3_reg;
        spd4_reg <= spd3_reg;
        dist_reg <= {1'b0, sx_reg} + {1'b0, sy_reg};
        if (ctrl.emit)
        begin
            result_reg.closest_index <= OUT_IDX_W'(best_idx_reg);
            result_reg.speed_out     <= speed_sel;
        end
    end

    assign stat.query_ok  = locked_reg && (count_reg != '0) && lookup_en_reg;
    assign stat.scan_last = (CNT_W'(addr_reg) == (count_reg - CNT_W'(1)));
    assign stat.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign stat.found     = found_reg;
    assign stat.out_free  = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== design/nwsl_ctrl.sv =====
// Controller: decodes accepted transactions and sequences the waypoint scan.
// Uses nwsl_pkg; drives the datapath through command and status structs.
module nwsl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [1:0]        item_cmd,
    input  nwsl_pkg::stat_t   stat,
    output nwsl_pkg::ctrl_t   ctrl
);
    import nwsl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;
    logic   accept;

    assign accept = item_valid && ready_reg;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item_cmd)
                        CMD_LOAD: ctrl.load = 1'b1;
                        CMD_MODE: ctrl.set_mode = 1'b1;
                        CMD_QUERY:
                        begin
                            if (stat.query_ok)
                            begin
                                ctrl.start = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                ctrl.issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!stat.found)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    ctrl.emit  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign item_ready = ready_reg;

endmodule
